// File: sv/rvmd_pkg.sv
package rvmd_pkg;

   localparam int unsigned XLEN = 32;
   localparam int unsigned OP_W = 3;
   // Radix-2 divider: bits of quotient retired per pipeline stage.
   localparam int unsigned DIV_BITS_PER_STAGE = 4;
   localparam int unsigned DIV_STAGES = XLEN / DIV_BITS_PER_STAGE;
   // Multiply path delay line length, one output register on top of it.
   localparam int unsigned MUL_LAT = DIV_STAGES - 1;

   typedef logic [XLEN-1:0] word_type;
   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_MUL    = 3'd0;
   localparam op_type OP_MULH   = 3'd1;
   localparam op_type OP_MULHSU = 3'd2;
   localparam op_type OP_MULHU  = 3'd3;
   localparam op_type OP_DIV    = 3'd4;
   localparam op_type OP_DIVU   = 3'd5;
   localparam op_type OP_REM    = 3'd6;
   localparam op_type OP_REMU   = 3'd7;

   // Divide pipeline payload.
   typedef struct packed {
      logic     valid;
      op_type   op;
      word_type dividend;    // original operand_a
      word_type rem;         // partial remainder
      word_type quo;         // shifts in quotient bits, shifts out dividend bits
      word_type dvsr;        // divisor magnitude
      logic     div_zero;
      logic     neg_q;
      logic     neg_r;
   } div_stage_type;

endpackage

// File: sv/rvmd_divider.sv
// Pipelined restoring divider: DIV_BITS_PER_STAGE quotient bits per stage.
module rvmd_divider (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  rvmd_pkg::op_type    in_op,
   input  rvmd_pkg::word_type  in_a,
   input  rvmd_pkg::word_type  in_b,
   input  logic                in_valid,
   output rvmd_pkg::word_type  out_result,
   output logic                out_valid
);
   import rvmd_pkg::*;

   div_stage_type stage_ff [DIV_STAGES+1];
   div_stage_type stage_in [DIV_STAGES+1];
   logic          signed_op;
   logic          want_rem;
   word_type      mag_q;
   word_type      mag_r;
   word_type      fix_q;
   word_type      fix_r;
   div_stage_type last;

   // Stage 0: take magnitudes and record sign fixups.
   always_comb begin
      signed_op = (in_op == OP_DIV) || (in_op == OP_REM);
      stage_in[0].valid    = in_valid;
      stage_in[0].op       = in_op;
      stage_in[0].dividend = in_a;
      stage_in[0].rem      = '0;
      stage_in[0].quo      = (signed_op && in_a[XLEN-1]) ? word_type'(-in_a) : in_a;
      stage_in[0].dvsr     = (signed_op && in_b[XLEN-1]) ? word_type'(-in_b) : in_b;
      stage_in[0].div_zero = (in_b == '0);
      stage_in[0].neg_q    = signed_op && (in_a[XLEN-1] ^ in_b[XLEN-1]);
      stage_in[0].neg_r    = signed_op && in_a[XLEN-1];
   end

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      always_comb begin
         logic [XLEN:0] trial;
         div_stage_type st;
         st = stage_ff[s];
         for (int k = 0; k < DIV_BITS_PER_STAGE; k++) begin
            trial = {st.rem, st.quo[XLEN-1]} - {1'b0, st.dvsr};
            if (!trial[XLEN]) begin
               st.rem = trial[XLEN-1:0];
               st.quo = {st.quo[XLEN-2:0], 1'b1};
            end else begin
               st.rem = {st.rem[XLEN-2:0], st.quo[XLEN-1]};
               st.quo = {st.quo[XLEN-2:0], 1'b0};
            end
         end
         stage_in[s+1] = st;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= DIV_STAGES; s++) begin
            stage_ff[s].valid <= 1'b0;
         end
      end else if (advance) begin
         stage_ff <= stage_in;
      end
   end

   // Final: sign correction and special cases.
   always_comb begin
      last      = stage_ff[DIV_STAGES];
      want_rem  = (last.op == OP_REM) || (last.op == OP_REMU);
      mag_q     = last.quo;
      mag_r     = last.rem;
      fix_q     = last.neg_q ? word_type'(-mag_q) : mag_q;
      fix_r     = last.neg_r ? word_type'(-mag_r) : mag_r;
      out_valid = last.valid;
      if (last.div_zero) begin
         out_result = want_rem ? last.dividend : '1;
      end else begin
         out_result = want_rem ? fix_r : fix_q;
      end
   end

endmodule

// File: sv/rv32m_multiply_divide_unit.sv
// Every operation passes as many register levels as the divider stage chain;
// multiplies are delayed to match so results stay in order.
// Throughput: one transfer per cycle; a stall on rsp_ freezes the whole pipe.
// Reset: synchronous, active high; clears all valid bits, payload is not reset.
module rv32m_multiply_divide_unit (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  rvmd_pkg::op_type    req_type,
   input  rvmd_pkg::word_type  req_operand_a,
   input  rvmd_pkg::word_type  req_operand_b,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output rvmd_pkg::word_type  rsp_result
);
   import rvmd_pkg::*;

   logic         advance;
   word_type     div_result;
   logic         div_valid;

   // Multiply path: stage 1 partial products, stage 2 sum, then delay line.
   logic [XLEN:0]     ma_ff, mb_ff;
   logic              mvalid_ff [MUL_LAT+1];
   op_type            mop_ff [MUL_LAT+1];
   logic signed [2*XLEN+1:0] prod_ll_ff, prod_lh_ff, prod_hl_ff, prod_hh_ff;
   logic [2*XLEN-1:0] prod_ff [2:MUL_LAT];
   logic              a_sgn, b_sgn;
   logic signed [2*XLEN+1:0] prod_sum;
   word_type          mul_result;
   logic              is_mul;

   // Advance the whole pipe unless the output is held.
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign is_mul    = !req_type[OP_W-1];

   always_comb begin
      a_sgn = (req_type == OP_MULH) || (req_type == OP_MULHSU);
      b_sgn = (req_type == OP_MULH);
   end

   rvmd_divider u_div (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .in_op      (req_type),
      .in_a       (req_operand_a),
      .in_b       (req_operand_b),
      .in_valid   (req_valid && !is_mul),
      .out_result (div_result),
      .out_valid  (div_valid)
   );

   // Recombine the four 17-ish partial products of the split 33x33 signed product.
   always_comb begin
      prod_sum = prod_ll_ff + (prod_lh_ff <<< 17) + (prod_hl_ff <<< 17)
                 + (prod_hh_ff <<< 34);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= MUL_LAT; i++) begin
            mvalid_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         // stage 0: capture extended operands
         ma_ff        <= {a_sgn & req_operand_a[XLEN-1], req_operand_a};
         mb_ff        <= {b_sgn & req_operand_b[XLEN-1], req_operand_b};
         mvalid_ff[0] <= req_valid && is_mul;
         mop_ff[0]    <= req_type;
         // stage 1: partial products (low halves unsigned, high halves signed)
         prod_ll_ff <= (2*XLEN+2)'($signed({1'b0, ma_ff[16:0]}) * $signed({1'b0, mb_ff[16:0]}));
         prod_lh_ff <= (2*XLEN+2)'($signed({1'b0, ma_ff[16:0]}) * $signed(mb_ff[XLEN:17]));
         prod_hl_ff <= (2*XLEN+2)'($signed(ma_ff[XLEN:17]) * $signed({1'b0, mb_ff[16:0]}));
         prod_hh_ff <= (2*XLEN+2)'($signed(ma_ff[XLEN:17]) * $signed(mb_ff[XLEN:17]));
         mvalid_ff[1] <= mvalid_ff[0];
         mop_ff[1]    <= mop_ff[0];
         // stage 2: sum, then delay to align with the divider
         prod_ff[2]   <= prod_sum[2*XLEN-1:0];
         mvalid_ff[2] <= mvalid_ff[1];
         mop_ff[2]    <= mop_ff[1];
         for (int i = 3; i <= MUL_LAT; i++) begin
            prod_ff[i]   <= prod_ff[i-1];
            mvalid_ff[i] <= mvalid_ff[i-1];
            mop_ff[i]    <= mop_ff[i-1];
         end
      end
   end

   always_comb begin
      mul_result = (mop_ff[MUL_LAT] == OP_MUL) ? prod_ff[MUL_LAT][XLEN-1:0]
                                              : prod_ff[MUL_LAT][2*XLEN-1:XLEN];
   end

   // Divider has DIV_STAGES+1 register levels counting its input stage; this
   // output register brings the multiply path to the same count.
   logic     mv_out_ff;
   word_type mr_out_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         mv_out_ff <= 1'b0;
      end else if (advance) begin
         mv_out_ff <= mvalid_ff[MUL_LAT];
         mr_out_ff <= mul_result;
      end
   end

   // Slots are exclusive: each cycle carries at most one item.
   assign rsp_valid  = mv_out_ff || div_valid;
   assign rsp_result = mv_out_ff ? mr_out_ff : div_result;

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
   import rvmd_pkg::*;

   // Fixed pipeline depth of the unit; used only for the drain at the end.
   localparam int PIPE_LATENCY = 9;

   logic      clock;
   logic      reset;
   logic      req_valid;
   logic      req_stall;
   op_type    req_type;
   word_type  req_operand_a;
   word_type  req_operand_b;
   logic      rsp_valid;
   logic      rsp_stall;
   word_type  rsp_result;

   word_type  expected_results[$];
   int        mismatch_count;
   int        op_count[8];
   int        result_count;
   bit        idle_free;       // suppress random idling on both sides
   bit        hold_rsp;        // long receiver hold-off in progress

   rv32m_multiply_divide_unit u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_type      (req_type),
      .req_operand_a (req_operand_a),
      .req_operand_b (req_operand_b),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_result    (rsp_result)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // Compute the RV32M result word for one operation.
   function automatic word_type rv32m_result(op_type op, word_type a, word_type b);
      logic signed [63:0] sa;
      logic signed [63:0] sb;
      logic [63:0]        prod;
      word_type           mag_a;
      word_type           mag_b;
      word_type           quo;
      word_type           rmd;
      sa    = {{32{a[31]}}, a};
      sb    = {{32{b[31]}}, b};
      mag_a = a[31] ? -a : a;
      mag_b = b[31] ? -b : b;
      case (op)
         OP_MUL:    prod = {32'd0, a} * {32'd0, b};
         OP_MULH:   prod = sa * sb;
         OP_MULHSU: prod = sa * $signed({32'd0, b});
         default:   prod = {32'd0, a} * {32'd0, b};
      endcase
      case (op)
         OP_MUL:    return prod[31:0];
         OP_MULH, OP_MULHSU, OP_MULHU: return prod[63:32];
         OP_DIVU:   return (b == 0) ? 32'hFFFF_FFFF : a / b;
         OP_REMU:   return (b == 0) ? a : a % b;
         default: begin
            if (b == 0)
               return (op == OP_DIV) ? 32'hFFFF_FFFF : a;
            quo = mag_a / mag_b;
            rmd = mag_a % mag_b;
            if (op == OP_REM)
               return a[31] ? -rmd : rmd;
            return (a[31] != b[31]) ? -quo : quo;
         end
      endcase
   endfunction

   task automatic report_mismatch(string what, word_type got, word_type want);
      mismatch_count++;
      $display("mismatch at %0t: %s got %08h want %08h", $time, what, got, want);
   endtask

   // Offer one item, idle at random beforehand, and hold it until transferred.
   task automatic send_item(op_type op, word_type a, word_type b);
      while (!idle_free && $urandom_range(99) < 21) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= op;
      req_operand_a <= a;
      req_operand_b <= b;
      expected_results.push_back(rv32m_result(op, a, b));
      op_count[op]++;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic finish_send;
      req_valid <= 1'b0;
   endtask

   function automatic word_type random_operand;
      case ($urandom_range(9))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return $urandom_range(16);
         5:       return -$urandom_range(16);
         6:       return $urandom >> $urandom_range(31);
         default: return $urandom;
      endcase
   endfunction

   // Extremes, every operation, divide by zero, signed overflow, remainder sign.
   task automatic test_directed;
      op_type op;
      for (int i = 0; i < 8; i++) begin
         op = op_type'(i);
         send_item(op, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
         send_item(op, 32'h8000_0000, 32'hFFFF_FFFF);
         send_item(op, 32'h1234_5678, 32'h0000_0000);
      end
      send_item(OP_REM, 32'hFFFF_FFF9, 32'h0000_0002);
      finish_send();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++)
         send_item(op_type'($urandom_range(7)), random_operand(), random_operand());
      finish_send();
   endtask

   // Run back to back while the receiver holds off, so the pipe fills, then keep going once it lets go.
   task automatic test_backpressure;
      idle_free = 1'b1;
      hold_rsp  = 1'b1;
      for (int i = 0; i < 40; i++)
         send_item(op_type'($urandom_range(7)), $urandom, $urandom);
      finish_send();
      hold_rsp  = 1'b0;
      for (int i = 0; i < 120; i++)
         send_item(op_type'($urandom_range(7)), random_operand(), random_operand());
      finish_send();
      idle_free = 1'b0;
   endtask

   // Receiver: random stall, a counted long hold-off when requested.
   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            for (int n = 0; n < 200 && hold_rsp; n++) @(posedge clock);
            hold_rsp = 1'b0;
         end
         rsp_stall <= !idle_free && ($urandom_range(99) < 21);
      end
   end

   // Check each transferred result against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         result_count++;
         if (expected_results.size() == 0)
            report_mismatch("unexpected result", rsp_result, '0);
         else if (rsp_result !== expected_results[0]) begin
            report_mismatch("result", rsp_result, expected_results[0]);
            void'(expected_results.pop_front());
         end else
            void'(expected_results.pop_front());
      end
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   initial begin
      reset         <= 1'b1;
      req_valid     <= 1'b0;
      req_type      <= OP_MUL;
      req_operand_a <= '0;
      req_operand_b <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(200);
      test_backpressure();
      test_random(265);
      while (expected_results.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY * 3) @(posedge clock);
      $display("covered %0d results across all eight operations (mul %0d, div %0d, rem %0d)",
               result_count, op_count[0], op_count[4], op_count[6]);
      $display("included divide by zero, signed overflow and a long output hold-off");
      if (mismatch_count == 0 && expected_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
